/* rtl/m4x_pkg.sv */
// Package for the 4x4 fixed-point matrix engine: command codes, widths,
// controller state type and the controller-to-datapath command struct.
// No dependencies.
`default_nettype none
package m4x_pkg;
  localparam int DEF_FRAC_BITS = 16;
  localparam int MAT_DIM       = 4;
  localparam int NUM_ENTRIES   = MAT_DIM * MAT_DIM;
  localparam int DATA_W        = 32;

  typedef enum logic [2:0] {
    CMD_WR_CUR  = 3'd0,
    CMD_WR_OPND = 3'd1,
    CMD_MUL     = 3'd2,
    CMD_ADD     = 3'd3,
    CMD_SCALE   = 3'd4,
    CMD_TRANSP  = 3'd5,
    CMD_XFORM   = 3'd6,
    CMD_READ    = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  typedef struct packed {
    logic       load;   // capture the accepted transaction
    logic       step;   // run one step (one output entry / component)
    logic [3:0] idx;    // step index
    logic       clr;    // clear the accumulated overflow
  } dp_ctl_t;
endpackage
`default_nettype wire

/* rtl/matrix4_transform_unit.sv */
// 4x4 fixed-point matrix engine (Q16.16 by default), top level.
// Multiply/add/scale/transpose run one step per matrix entry, transform
//   one per result component, writes and reads a single step, each after
//   the accept; the result then waits in the output register. One command
//   at a time, paced by the step sequencer over four shared multipliers.
// Reset (rst, synchronous): both matrices return to identity, no result held.
`default_nettype none
module matrix4_transform_unit #(
  parameter int FRAC_BITS = m4x_pkg::DEF_FRAC_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  // tdata from bit 0: cmd[2:0], row[4:3], col[6:5], value[38:7],
  // px[70:39], py[102:71], pz[134:103], zero fill to 136
  input  wire logic [135:0]  s_tdata,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  // tdata from bit 0: res_x, res_y, res_z, read_value, overflow[128], zero fill
  output logic [135:0]       m_tdata
);
  import m4x_pkg::*;

  dp_ctl_t ctl;
  logic busy, done, in_fire, out_fire;
  logic signed [31:0] rx, ry, rz, rd;
  logic ov;

  // accept only while idle; result register holds until taken
  assign s_tready = !busy;
  assign in_fire  = s_tvalid && s_tready;
  assign m_tvalid = done;
  assign out_fire = m_tvalid && m_tready;
  assign m_tdata  = {7'd0, ov, rd, rz, ry, rx};

  m4x_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_cmd(s_tdata[2:0]), .out_fire,
    .ctl, .busy, .done
  );

  m4x_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .ctl,
    .in_cmd(s_tdata[2:0]), .in_row(s_tdata[4:3]), .in_col(s_tdata[6:5]),
    .in_value(s_tdata[38:7]), .in_px(s_tdata[70:39]),
    .in_py(s_tdata[102:71]), .in_pz(s_tdata[134:103]),
    .res_x(rx), .res_y(ry), .res_z(rz), .read_value(rd), .overflow(ov)
  );

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_tready) else $error("accept while busy");
  a_done_after_take: assert property (@(posedge clk) disable iff (rst)
    out_fire |=> !m_tvalid) else $error("result repeated");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> busy) else $error("load did not start");
`endif
endmodule
`default_nettype wire

/* rtl/m4x_ctrl.sv */
// Controller for the matrix engine: sequences one command over steps.
// Depends on m4x_pkg.
`default_nettype none
module m4x_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_fire,
  input  wire logic [2:0]      in_cmd,
  input  wire logic            out_fire,
  output m4x_pkg::dp_ctl_t     ctl,
  output logic                 busy,
  output logic                 done
);
  import m4x_pkg::*;

  state_t     state, state_next;
  logic [3:0] cnt, cnt_next;
  logic [3:0] last, last_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    last_next  = last;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_RUN;
          cnt_next   = '0;
          case (cmd_t'(in_cmd))
            CMD_MUL, CMD_ADD, CMD_SCALE, CMD_TRANSP: last_next = 4'd15;
            CMD_XFORM: last_next = 4'd2;
            default:   last_next = 4'd0;
          endcase
        end
      end
      ST_RUN: begin
        cnt_next = cnt + 4'd1;
        if (cnt == last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_fire) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.load = (state == ST_IDLE) && in_fire;
    ctl.clr  = ctl.load;
    ctl.step = (state == ST_RUN);
    ctl.idx  = cnt;
    busy     = (state != ST_IDLE);
    done     = (state == ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      last  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      last  <= last_next;
    end
  end
endmodule
`default_nettype wire

/* rtl/m4x_dp.sv */
// Datapath for the matrix engine: both matrices, four multipliers, the
// adder and saturation, and the result register. Depends on m4x_pkg.
`default_nettype none
module m4x_dp #(
  parameter int FRAC_BITS = m4x_pkg::DEF_FRAC_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  m4x_pkg::dp_ctl_t         ctl,
  input  wire logic [2:0]          in_cmd,
  input  wire logic [1:0]          in_row,
  input  wire logic [1:0]          in_col,
  input  wire logic signed [31:0]  in_value,
  input  wire logic signed [31:0]  in_px,
  input  wire logic signed [31:0]  in_py,
  input  wire logic signed [31:0]  in_pz,
  output logic signed [31:0]       res_x,
  output logic signed [31:0]       res_y,
  output logic signed [31:0]       res_z,
  output logic signed [31:0]       read_value,
  output logic                     overflow
);
  import m4x_pkg::*;

  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  logic signed [31:0] cur [NUM_ENTRIES];
  logic signed [31:0] opd [NUM_ENTRIES];
  logic signed [31:0] shadow [NUM_ENTRIES]; // old current for mul/transpose
  cmd_t               cmd;
  logic [3:0]         eidx;
  logic signed [31:0] val, pt [3];

  logic [1:0] si, sj;
  logic signed [31:0] ma [4], mb [4];
  logic signed [63:0] prod [4];
  logic signed [64:0] sum;
  logic signed [31:0] satv, tv;
  logic               sov;

  assign si = ctl.idx[3:2];
  assign sj = ctl.idx[1:0];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ma[k] = '0;
      mb[k] = '0;
    end
    case (cmd)
      CMD_MUL: begin
        for (int k = 0; k < 4; k++) begin
          ma[k] = shadow[{si, 2'(k)}];
          mb[k] = opd[{2'(k), sj}];
        end
      end
      CMD_SCALE: begin
        ma[0] = cur[ctl.idx];
        mb[0] = val;
      end
      CMD_XFORM: begin
        for (int k = 0; k < 3; k++) begin
          ma[k] = cur[{sj, 2'(k)}];
          mb[k] = pt[k];
        end
      end
      default: ;
    endcase
    for (int k = 0; k < 4; k++) prod[k] = (64'(ma[k]) * 64'(mb[k])) >>> FRAC_BITS;
    sum = 65'(prod[0]) + 65'(prod[1]) + 65'(prod[2]) + 65'(prod[3]);
    case (cmd)
      CMD_ADD:   sum = 65'(cur[ctl.idx]) + 65'(opd[ctl.idx]);
      CMD_XFORM: sum = sum + 65'(cur[{sj, 2'd3}]);
      default: ;
    endcase
    sov  = 1'b0;
    satv = sum[31:0];
    if (sum > 65'sh7FFFFFFF) begin
      satv = 32'sh7FFFFFFF;
      sov  = 1'b1;
    end else if (sum < -65'sh80000000) begin
      satv = 32'sh80000000;
      sov  = 1'b1;
    end
    tv = shadow[{sj, si}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        cur[i] <= (i / MAT_DIM == i % MAT_DIM) ? ONE : '0;
        opd[i] <= (i / MAT_DIM == i % MAT_DIM) ? ONE : '0;
      end
      overflow <= 1'b0;
    end else begin
      if (ctl.load) begin
        cmd   <= cmd_t'(in_cmd);
        eidx  <= {in_row, in_col};
        val   <= in_value;
        pt[0] <= in_px;
        pt[1] <= in_py;
        pt[2] <= in_pz;
        for (int i = 0; i < NUM_ENTRIES; i++) shadow[i] <= cur[i];
        res_x <= '0;
        res_y <= '0;
        res_z <= '0;
        read_value <= '0;
        overflow   <= 1'b0;
      end else if (ctl.step) begin
        case (cmd)
          CMD_WR_CUR:  cur[eidx] <= val;
          CMD_WR_OPND: opd[eidx] <= val;
          CMD_READ:    read_value <= cur[eidx];
          CMD_TRANSP:  cur[ctl.idx] <= tv;
          CMD_XFORM: begin
            overflow <= overflow | sov;
            case (sj)
              2'd0:    res_x <= satv;
              2'd1:    res_y <= satv;
              default: res_z <= satv;
            endcase
          end
          default: begin
            cur[ctl.idx] <= satv;
            overflow <= overflow | sov;
          end
        endcase
      end
    end
  end
endmodule
`default_nettype wire

/* dv/matrix4_transform_unit_test.sv */
// Self-checking bench for the 4x4 fixed-point matrix engine: drives command
// transactions, predicts each result from a local matrix model, compares.
// Depends on m4x_pkg and matrix4_transform_unit.
`timescale 1ns / 100ps
`default_nettype none
module matrix4_transform_unit_test;
  import m4x_pkg::*;

  localparam int FRAC = DEF_FRAC_BITS;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [31:0] pz;
    logic [31:0] py;
    logic [31:0] px;
    logic [31:0] value;
    logic [1:0]  col;
    logic [1:0]  row;
    cmd_t        cmd;
  } cmd_item_t;

  typedef struct packed {
    logic [31:0] res_x;
    logic [31:0] res_y;
    logic [31:0] res_z;
    logic [31:0] read_value;
    logic        overflow;
  } mat_result_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  // fields from bit 0: cmd, row, col, value, px, py, pz, zero fill
  logic [135:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  // fields from bit 0: res_x, res_y, res_z, read_value, overflow, zero fill
  logic [135:0] m_tdata;

  matrix4_transform_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Model state of both matrices, row-major.
  logic signed [31:0] cur_m [NUM_ENTRIES];
  logic signed [31:0] opnd_m [NUM_ENTRIES];

  cmd_item_t   pending_cmds [$];
  mat_result_t expected_results [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count   = 0;
  int stall_cycles  = 0;
  int cmds_sent     = 0;
  int results_seen  = 0;
  int xforms_seen   = 0;
  int ovf_seen      = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Floor-shifted Q product, kept wide.
  function automatic logic signed [63:0] q_mul(logic signed [31:0] a,
                                                logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p >>> FRAC;
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [63:0] v, ref logic ov);
    if (v > 64'sd2147483647) begin
      ov = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      ov = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  task automatic reset_matrices();
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      cur_m[i]  = (i / MAT_DIM == i % MAT_DIM) ? 32'sd1 <<< FRAC : 32'sd0;
      opnd_m[i] = cur_m[i];
    end
  endtask

  // Apply one command to the model and return its result.
  function automatic mat_result_t run_matrix_cmd(cmd_item_t it);
    mat_result_t r;
    logic signed [31:0] tmp [NUM_ENTRIES];
    logic signed [63:0] acc;
    logic signed [31:0] pt [3];
    logic signed [31:0] comp [3];
    logic ov;
    int idx;
    r = '{default: '0};
    ov = 1'b0;
    idx = it.row * MAT_DIM + it.col;
    pt[0] = it.px;
    pt[1] = it.py;
    pt[2] = it.pz;
    case (it.cmd)
      CMD_WR_CUR:  cur_m[idx] = it.value;
      CMD_WR_OPND: opnd_m[idx] = it.value;
      CMD_MUL: begin
        for (int i = 0; i < MAT_DIM; i++)
          for (int j = 0; j < MAT_DIM; j++) begin
            acc = '0;
            for (int k = 0; k < MAT_DIM; k++)
              acc += q_mul(cur_m[i*MAT_DIM+k], opnd_m[k*MAT_DIM+j]);
            tmp[i*MAT_DIM+j] = clamp32(acc, ov);
          end
        cur_m = tmp;
      end
      CMD_ADD:
        for (int i = 0; i < NUM_ENTRIES; i++)
          cur_m[i] = clamp32(64'(cur_m[i]) + 64'(opnd_m[i]), ov);
      CMD_SCALE:
        for (int i = 0; i < NUM_ENTRIES; i++)
          cur_m[i] = clamp32(q_mul(cur_m[i], it.value), ov);
      CMD_TRANSP: begin
        tmp = cur_m;
        for (int i = 0; i < MAT_DIM; i++)
          for (int j = 0; j < MAT_DIM; j++)
            cur_m[i*MAT_DIM+j] = tmp[j*MAT_DIM+i];
      end
      CMD_XFORM: begin
        for (int i = 0; i < 3; i++) begin
          acc = 64'(cur_m[i*MAT_DIM+3]);
          for (int j = 0; j < 3; j++)
            acc += q_mul(cur_m[i*MAT_DIM+j], pt[j]);
          comp[i] = clamp32(acc, ov);
        end
        r.res_x = comp[0];
        r.res_y = comp[1];
        r.res_z = comp[2];
      end
      default: r.read_value = cur_m[idx];
    endcase
    r.overflow = ov;
    return r;
  endfunction

  // Mostly small Q values so products stay meaningful; some wide ones to saturate.
  function automatic logic [31:0] pick_q();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2, 3:    return 32'($signed($urandom_range(0, 8)) - 4) <<< FRAC;
      default: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
    endcase
  endfunction

  function automatic cmd_item_t make_cmd(cmd_t c);
    cmd_item_t it;
    it.cmd   = c;
    it.row   = 2'($urandom());
    it.col   = 2'($urandom());
    it.value = pick_q();
    it.px    = pick_q();
    it.py    = pick_q();
    it.pz    = pick_q();
    return it;
  endfunction

  function automatic cmd_item_t directed_cmd(cmd_t c, logic [1:0] r, logic [1:0] col,
                                             logic [31:0] v, logic [31:0] x,
                                             logic [31:0] y, logic [31:0] z);
    cmd_item_t it;
    it.cmd = c; it.row = r; it.col = col; it.value = v;
    it.px = x; it.py = y; it.pz = z;
    return it;
  endfunction

  // Driver: advance to the next pending command after each handshake.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        expected_results.push_back(run_matrix_cmd(cmd_item_t'(s_tdata[134:0])));
        cmds_sent++;
      end
      if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pending_cmds.pop_front()};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    mat_result_t exp_r;
    mat_result_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      stall_cycles <= ((s_tvalid && s_tready) || (m_tvalid && m_tready)) ? 0
                      : stall_cycles + 1;
      if (m_tvalid && m_tready) begin
        got.res_x      = m_tdata[31:0];
        got.res_y      = m_tdata[63:32];
        got.res_z      = m_tdata[95:64];
        got.read_value = m_tdata[127:96];
        got.overflow   = m_tdata[128];
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_tdata);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.overflow) ovf_seen++;
          if (got.res_x != 0) xforms_seen++;
          if (got != exp_r) begin
            $display("%0t: mismatch expected x=%h y=%h z=%h rd=%h ov=%b", $time,
                     exp_r.res_x, exp_r.res_y, exp_r.res_z, exp_r.read_value,
                     exp_r.overflow);
            $display("%0t:          actual   x=%h y=%h z=%h rd=%h ov=%b", $time,
                     got.res_x, got.res_y, got.res_z, got.read_value, got.overflow);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic drain();
    while (pending_cmds.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  task automatic queue_random(int n);
    cmd_item_t it;
    for (int i = 0; i < n; i++) begin
      // Bias toward entry writes and transforms; matrix ops still frequent.
      case ($urandom_range(0, 11))
        0, 1:    it = make_cmd(CMD_WR_CUR);
        2:       it = make_cmd(CMD_WR_OPND);
        3:       it = make_cmd(CMD_MUL);
        4:       it = make_cmd(CMD_ADD);
        5:       it = make_cmd(CMD_SCALE);
        6:       it = make_cmd(CMD_TRANSP);
        7, 8, 9: it = make_cmd(CMD_XFORM);
        default: it = make_cmd(CMD_READ);
      endcase
      pending_cmds.push_back(it);
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b0;
    reset_matrices();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: identity read and transform, extremes, every command, saturation.
    pending_cmds.push_back(directed_cmd(CMD_READ, 2'd0, 2'd0, '0, '0, '0, '0));
    pending_cmds.push_back(directed_cmd(CMD_READ, 2'd3, 2'd2, '0, '0, '0, '0));
    pending_cmds.push_back(directed_cmd(CMD_XFORM, 2'd0, 2'd0, '0,
                                        32'h7fffffff, 32'h80000000, 32'hffffffff));
    pending_cmds.push_back(directed_cmd(CMD_WR_CUR, 2'd0, 2'd3, 32'h7fffffff, '0, '0, '0));
    pending_cmds.push_back(directed_cmd(CMD_XFORM, 2'd0, 2'd0, '0,
                                        32'h00010000, '0, '0));
    pending_cmds.push_back(directed_cmd(CMD_WR_CUR, 2'd1, 2'd3, 32'h80000000, '0, '0, '0));
    pending_cmds.push_back(directed_cmd(CMD_XFORM, 2'd0, 2'd0, '0,
                                        '0, 32'hffff0000, 32'hffffffff));
    pending_cmds.push_back(directed_cmd(CMD_WR_OPND, 2'd3, 2'd3, 32'h7fffffff, '0, '0, '0));
    pending_cmds.push_back(directed_cmd(CMD_WR_OPND, 2'd2, 2'd1, 32'h80000000, '0, '0, '0));
    pending_cmds.push_back(directed_cmd(CMD_ADD, 2'd0, 2'd0, '0, '0, '0, '0));
    pending_cmds.push_back(directed_cmd(CMD_MUL, 2'd0, 2'd0, '0, '0, '0, '0));
    pending_cmds.push_back(directed_cmd(CMD_TRANSP, 2'd0, 2'd0, '0, '0, '0, '0));
    pending_cmds.push_back(directed_cmd(CMD_READ, 2'd3, 2'd0, '0, '0, '0, '0));
    pending_cmds.push_back(directed_cmd(CMD_SCALE, 2'd0, 2'd0, 32'hffff8000, '0, '0, '0));
    pending_cmds.push_back(directed_cmd(CMD_SCALE, 2'd0, 2'd0, 32'h80000000, '0, '0, '0));
    pending_cmds.push_back(directed_cmd(CMD_SCALE, 2'd0, 2'd0, 32'h00000000, '0, '0, '0));
    pending_cmds.push_back(directed_cmd(CMD_READ, 2'd1, 2'd1, '0, '0, '0, '0));
    pending_cmds.push_back(directed_cmd(CMD_WR_CUR, 2'd2, 2'd2, 32'hffffffff, '0, '0, '0));
    pending_cmds.push_back(directed_cmd(CMD_READ, 2'd2, 2'd2, '0, '0, '0, '0));

    send_idle_pct = 24;
    recv_idle_pct = 88;
    queue_random(280);
    drain();
    // Hold off the sender until every result is back, then continue.
    send_idle_pct = 88;
    recv_idle_pct = 24;
    queue_random(280);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(280);
    drain();
    repeat (40) @(posedge clk);

    $display("Covered %0d commands, %0d results, %0d with nonzero x, %0d saturating.",
             cmds_sent, results_seen, xforms_seen, ovf_seen);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
